/* rtl/core/sdcp_pkg.sv */
`default_nettype none

package sdcp_pkg;

  // Line store geometry
  localparam int unsigned LINE_MAX = 19;
  localparam int unsigned LEN_W    = $clog2(LINE_MAX + 1);
  localparam int unsigned IDX_W    = $clog2(LINE_MAX);

  // Characters
  localparam logic [7:0] CH_NUL   = 8'h00;
  localparam logic [7:0] CH_LF    = 8'h0A;
  localparam logic [7:0] CH_CR    = 8'h0D;
  localparam logic [7:0] CH_SPACE = 8'h20;
  localparam logic [7:0] CH_GT    = 8'h3E;
  localparam logic [7:0] CH_B     = 8'h62;
  localparam logic [7:0] CH_D     = 8'h64;
  localparam logic [7:0] CH_M     = 8'h6D;
  localparam logic [7:0] CH_P     = 8'h70;
  localparam logic [7:0] CH_R     = 8'h72;
  localparam logic [7:0] CH_S     = 8'h73;
  localparam logic [7:0] CH_W     = 8'h77;

  // Result kinds
  localparam logic KIND_TX  = 1'b0;
  localparam logic KIND_CMD = 1'b1;

  // Register index (paddr bit 2)
  localparam logic REG_PMIC_ENABLE = 1'b0;

  typedef enum logic [2:0] {
    CMD_DUMP       = 3'd0,
    CMD_MMIO_READ  = 3'd1,
    CMD_MMIO_WRITE = 3'd2,
    CMD_PMIC_READ  = 3'd3,
    CMD_PMIC_WRITE = 3'd4,
    CMD_REBOOT     = 3'd5,
    CMD_RESET      = 3'd6,
    CMD_WAKEUP     = 3'd7
  } cmd_e;

  typedef struct packed {
    logic        done;
    logic        ok;
    cmd_e        cmd;
    logic [31:0] addr;
    logic [31:0] val;
  } dec_status_t;

endpackage

`default_nettype wire

/* rtl/core/serial_debug_command_parser.sv */
// Serial debug command parser.
// Input channel (in_valid_i/in_ready_o): one received byte per transaction with the
// host_running flag. Zero bytes and bytes taken while the host runs are dropped.
// Output channel (out_valid_o/out_ready_i): one result per transaction, either a byte
// to transmit (echo, newline, prompt) or a decoded command; last_o marks the final
// result of an input byte.
// Steps per accepted byte, with the receiver always ready:
//   printable byte: accept, then echo and line store write;
//   line end by other control byte or full line: newline, '>', ' ';
//   line end by CR: newline, a decode walk over the L stored characters, then
//   the command if valid, '>', ' '. The decode walk reads the line store one
//   character per cycle through its single read port.
// A finished result sits in the output register while the next byte is accepted;
// a stalled receiver holds the sequencer only when it has another result to push.
// Reset empties the line and clears pmic_enable. The line store has no reset;
// only entries written on the current line are read back.
// APB port: register 0 (address 0) is pmic_enable, bit 0. pready is always high.
`default_nettype none

module serial_debug_command_parser (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        in_valid_i,
  output logic             in_ready_o,
  input  wire logic [7:0]  rx_byte_i,
  input  wire logic        host_running_i,
  output logic             out_valid_o,
  input  wire logic        out_ready_i,
  output logic             kind_o,
  output logic [7:0]       echo_byte_o,
  output logic [2:0]       command_o,
  output logic [31:0]      address_o,
  output logic [31:0]      value_o,
  output logic             last_o,
  input  wire logic        psel,
  input  wire logic        penable,
  input  wire logic        pwrite,
  input  wire logic [2:0]  paddr,
  input  wire logic [31:0] pwdata,
  output logic [31:0]      prdata,
  output logic             pready
);
  import sdcp_pkg::*;

  typedef enum logic [6:0] {
    S_IDLE = 7'b0000001,
    S_ECHO = 7'b0000010,
    S_NL   = 7'b0000100,
    S_SCAN = 7'b0001000,
    S_CMD  = 7'b0010000,
    S_GT   = 7'b0100000,
    S_SP   = 7'b1000000
  } state_e;

  state_e           state_q, state_d;
  logic [7:0]       byte_q;
  logic             is_cr_q;
  logic [LEN_W-1:0] len_q, len_d;
  logic [LEN_W-1:0] rd_idx_q, rd_idx_d;
  logic             rd_vld_q;
  logic             pmic_en_q;

  logic             out_valid_q;
  logic             out_kind_q;
  logic [7:0]       out_byte_q;
  cmd_e             out_cmd_q;
  logic [31:0]      out_addr_q;
  logic [31:0]      out_val_q;
  logic             out_last_q;

  logic             accept;
  logic             out_free;
  logic             push;
  logic             push_kind;
  logic [7:0]       push_byte;
  logic             push_last;

  logic             mem_we;
  logic             rd_issue;
  logic [7:0]       rdata;
  logic             dec_start;
  logic             char_valid;
  logic [7:0]       char_byte;
  dec_status_t      dec;

  logic             cfg_wr;

  assign in_ready_o = (state_q == S_IDLE);
  assign accept     = in_valid_i && in_ready_o;
  // The output register can take a result when empty or being drained
  assign out_free   = !out_valid_q || out_ready_i;

  // Line store: written only in ECHO, read only in SCAN, so no overlap to guard
  assign mem_we    = (state_q == S_ECHO) && out_free;
  assign rd_issue  = (state_q == S_SCAN) && (rd_idx_q < len_q) && !dec.done;
  assign dec_start = (state_q == S_NL) && out_free && is_cr_q;

  // Feed stored characters in order, then a NUL past the end of the line
  assign char_valid = (state_q == S_SCAN) && (rd_vld_q || (rd_idx_q == len_q));
  assign char_byte  = rd_vld_q ? rdata : CH_NUL;

  sdcp_line_ram u_line_ram (
    .clk_i   (clk_i),
    .we_i    (mem_we),
    .waddr_i (len_q[IDX_W-1:0]),
    .wdata_i (byte_q),
    .re_i    (rd_issue),
    .raddr_i (rd_idx_q[IDX_W-1:0]),
    .rdata_o (rdata)
  );

  sdcp_decoder u_decoder (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .start_i       (dec_start),
    .char_valid_i  (char_valid),
    .char_i        (char_byte),
    .pmic_enable_i (pmic_en_q),
    .status_o      (dec)
  );

  // Sequencer: at most one result pushed per step, waiting while the output register is full
  always_comb begin
    state_d   = state_q;
    len_d     = len_q;
    rd_idx_d  = rd_idx_q;
    push      = 1'b0;
    push_kind = KIND_TX;
    push_byte = CH_NUL;
    push_last = 1'b0;
    unique case (state_q)
      S_IDLE: begin
        if (accept && !host_running_i && (rx_byte_i != CH_NUL)) begin
          if ((rx_byte_i < CH_SPACE) || (len_q >= LEN_W'(LINE_MAX))) begin
            state_d = S_NL;
          end else begin
            state_d = S_ECHO;
          end
        end
      end
      S_ECHO: begin
        if (out_free) begin
          push      = 1'b1;
          push_byte = byte_q;
          push_last = 1'b1;
          len_d     = len_q + 1'b1;
          state_d   = S_IDLE;
        end
      end
      S_NL: begin
        if (out_free) begin
          push      = 1'b1;
          push_byte = CH_LF;
          rd_idx_d  = '0;
          state_d   = is_cr_q ? S_SCAN : S_GT;
        end
      end
      S_SCAN: begin
        if (rd_issue) begin
          rd_idx_d = rd_idx_q + 1'b1;
        end
        if (dec.done) begin
          state_d = S_CMD;
        end
      end
      S_CMD: begin
        if (!dec.ok) begin
          state_d = S_GT;
        end else if (out_free) begin
          push      = 1'b1;
          push_kind = KIND_CMD;
          state_d   = S_GT;
        end
      end
      S_GT: begin
        if (out_free) begin
          push      = 1'b1;
          push_byte = CH_GT;
          state_d   = S_SP;
        end
      end
      S_SP: begin
        if (out_free) begin
          push      = 1'b1;
          push_byte = CH_SPACE;
          push_last = 1'b1;
          len_d     = '0;
          state_d   = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      len_q       <= '0;
      rd_idx_q    <= '0;
      rd_vld_q    <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      state_q  <= state_d;
      len_q    <= len_d;
      rd_idx_q <= rd_idx_d;
      rd_vld_q <= rd_issue;
      if (push) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  // Latch the accepted byte; payload needs no reset
  always_ff @(posedge clk_i) begin
    if (accept) begin
      byte_q  <= rx_byte_i;
      is_cr_q <= (rx_byte_i == CH_CR);
    end
  end

  // Output register payload; command fields zero in transmit results
  always_ff @(posedge clk_i) begin
    if (push) begin
      out_kind_q <= push_kind;
      out_byte_q <= push_byte;
      out_last_q <= push_last;
      if (push_kind == KIND_CMD) begin
        out_cmd_q  <= dec.cmd;
        out_addr_q <= dec.addr;
        out_val_q  <= dec.val;
      end else begin
        out_cmd_q  <= CMD_DUMP;
        out_addr_q <= '0;
        out_val_q  <= '0;
      end
    end
  end

  assign out_valid_o = out_valid_q;
  assign kind_o      = out_kind_q;
  assign echo_byte_o = out_byte_q;
  assign command_o   = out_cmd_q;
  assign address_o   = out_addr_q;
  assign value_o     = out_val_q;
  assign last_o      = out_last_q;

  // Configuration port; register index is address bit 2
  assign cfg_wr = psel && penable && pwrite;
  assign pready = 1'b1;
  assign prdata = (paddr[2] == REG_PMIC_ENABLE) ? {31'd0, pmic_en_q} : 32'd0;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pmic_en_q <= 1'b0;
    end else if (cfg_wr && (paddr[2] == REG_PMIC_ENABLE)) begin
      pmic_en_q <= pwdata[0];
    end
  end

  // Line length never passes the store depth
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    len_q <= LEN_W'(LINE_MAX))
    else $error("line length beyond store depth");

  // The read pointer never runs past the stored line
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_SCAN) |-> (rd_idx_q <= len_q))
    else $error("line store read past line end");

  // A command result is never the final result of a byte
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_q && (out_kind_q == KIND_CMD)) |-> !out_last_q)
    else $error("command result marked last");

  // A printable byte on a non-full line goes to echo
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (accept && !host_running_i && (rx_byte_i >= CH_SPACE) && (len_q < LEN_W'(LINE_MAX)))
      |=> (state_q == S_ECHO))
    else $error("printable byte not echoed");

  // The prompt completes the line and empties it
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    ((state_q == S_SP) && out_free) |=> ((len_q == '0) && (state_q == S_IDLE)))
    else $error("line not emptied after prompt");

endmodule

`default_nettype wire

/* rtl/core/sdcp_line_ram.sv */
`default_nettype none

module sdcp_line_ram (
  input  wire logic                     clk_i,
  input  wire logic                     we_i,
  input  wire logic [sdcp_pkg::IDX_W-1:0] waddr_i,
  input  wire logic [7:0]               wdata_i,
  input  wire logic                     re_i,
  input  wire logic [sdcp_pkg::IDX_W-1:0] raddr_i,
  output logic      [7:0]               rdata_o
);
  import sdcp_pkg::*;

  logic [7:0] mem [LINE_MAX];
  logic [7:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_q <= mem[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

`default_nettype wire

/* rtl/core/sdcp_decoder.sv */
`default_nettype none

module sdcp_decoder (
  input  wire logic                  clk_i,
  input  wire logic                  rst_ni,
  input  wire logic                  start_i,
  input  wire logic                  char_valid_i,
  input  wire logic [7:0]            char_i,
  input  wire logic                  pmic_enable_i,
  output sdcp_pkg::dec_status_t      status_o
);
  import sdcp_pkg::*;

  typedef enum logic [8:0] {
    D_FIRST  = 9'b000000001,
    D_SECOND = 9'b000000010,
    D_A1_SP0 = 9'b000000100,
    D_A1_SP  = 9'b000001000,
    D_A1_HEX = 9'b000010000,
    D_A2_SP  = 9'b000100000,
    D_A2_HEX = 9'b001000000,
    D_DONE   = 9'b010000000,
    D_SPARE  = 9'b100000000
  } dstate_e;

  dstate_e     state_q, state_d;
  logic        ok_q, ok_d;
  cmd_e        cmd_q, cmd_d;
  logic [31:0] addr_q, addr_d;
  logic [31:0] val_q, val_d;
  logic        is_dump_q, is_dump_d;
  logic        is_pmic_q, is_pmic_d;

  logic [7:0]  lc;
  logic        is_dig;
  logic        is_space;
  logic [3:0]  nib;

  // Fold case, then classify
  assign lc       = char_i | 8'h20;
  assign is_dig   = ((lc >= 8'h30) && (lc <= 8'h39)) || ((lc >= 8'h61) && (lc <= 8'h66));
  assign is_space = (char_i == CH_SPACE);
  assign nib      = (lc <= 8'h39) ? lc[3:0] : (lc[3:0] + 4'd9);

  always_comb begin
    state_d   = state_q;
    ok_d      = ok_q;
    cmd_d     = cmd_q;
    addr_d    = addr_q;
    val_d     = val_q;
    is_dump_d = is_dump_q;
    is_pmic_d = is_pmic_q;
    if (start_i) begin
      state_d = D_FIRST;
      ok_d    = 1'b0;
      addr_d  = '0;
      val_d   = '0;
    end else if (char_valid_i) begin
      unique case (state_q)
        D_FIRST: begin
          state_d = D_DONE;
          if (char_i == CH_D) begin
            is_dump_d = 1'b1;
            is_pmic_d = 1'b0;
            state_d   = D_A1_SP0;
          end else if (char_i == CH_M) begin
            is_dump_d = 1'b0;
            is_pmic_d = 1'b0;
            state_d   = D_A1_SP0;
          end else if (char_i == CH_P && pmic_enable_i) begin
            is_dump_d = 1'b0;
            is_pmic_d = 1'b1;
            state_d   = D_A1_SP0;
          end else if (char_i == CH_S) begin
            state_d = D_SECOND;
          end
        end
        D_SECOND: begin
          state_d = D_DONE;
          if (char_i == CH_B) begin
            ok_d  = 1'b1;
            cmd_d = CMD_REBOOT;
          end else if (char_i == CH_R) begin
            ok_d  = 1'b1;
            cmd_d = CMD_RESET;
          end else if (char_i == CH_W) begin
            ok_d  = 1'b1;
            cmd_d = CMD_WAKEUP;
          end
        end
        D_A1_SP0: begin
          state_d = is_space ? D_A1_SP : D_DONE;
        end
        D_A1_SP: begin
          if (is_dig) begin
            addr_d  = {addr_q[27:0], nib};
            state_d = D_A1_HEX;
          end else if (!is_space) begin
            state_d = D_DONE;
          end
        end
        D_A1_HEX: begin
          if (is_dig) begin
            addr_d = {addr_q[27:0], nib};
          end else if (is_space) begin
            state_d = D_A2_SP;
          end else begin
            // No second argument: a read, unless this is a dump
            ok_d    = !is_dump_q;
            cmd_d   = is_pmic_q ? CMD_PMIC_READ : CMD_MMIO_READ;
            state_d = D_DONE;
          end
        end
        D_A2_SP: begin
          if (is_dig) begin
            val_d   = {val_q[27:0], nib};
            state_d = D_A2_HEX;
          end else if (!is_space) begin
            ok_d    = !is_dump_q;
            cmd_d   = is_pmic_q ? CMD_PMIC_READ : CMD_MMIO_READ;
            state_d = D_DONE;
          end
        end
        D_A2_HEX: begin
          if (is_dig) begin
            val_d = {val_q[27:0], nib};
          end else begin
            ok_d    = 1'b1;
            cmd_d   = is_dump_q ? CMD_DUMP : (is_pmic_q ? CMD_PMIC_WRITE : CMD_MMIO_WRITE);
            state_d = D_DONE;
          end
        end
        D_DONE: begin
          state_d = D_DONE;
        end
        default: begin
          state_d = D_DONE;
        end
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= D_DONE;
      ok_q    <= 1'b0;
    end else begin
      state_q <= state_d;
      ok_q    <= ok_d;
    end
  end

  always_ff @(posedge clk_i) begin
    cmd_q     <= cmd_d;
    addr_q    <= addr_d;
    val_q     <= val_d;
    is_dump_q <= is_dump_d;
    is_pmic_q <= is_pmic_d;
  end

  assign status_o.done = (state_q == D_DONE);
  assign status_o.ok   = ok_q;
  assign status_o.cmd  = cmd_q;
  assign status_o.addr = addr_q;
  assign status_o.val  = val_q;

endmodule

`default_nettype wire
